// ----- sv/tti_pkg.sv -----
package tti_pkg;

  localparam int unsigned TimeWidth = 64;
  localparam int unsigned ProdWidth = 2 * TimeWidth;
  localparam logic [TimeWidth-1:0] NsPerS = TimeWidth'(64'd1_000_000_000);

  typedef enum logic {
    CMD_ANCHOR  = 1'b0,
    CMD_RESOLVE = 1'b1
  } cmd_e;

  // One request as the front end hands it to the arithmetic back end.
  // All operands are taken from the anchor state right after the update.
  typedef struct packed {
    logic                 mul_en;    // time needs base + a * b / d
    logic [TimeWidth-1:0] base_ns;   // newer anchor time, or 0 with no anchor
    logic [TimeWidth-1:0] op_a;
    logic [TimeWidth-1:0] op_b;
    logic [TimeWidth-1:0] op_d;
    logic                 drift_en;  // two anchors and a positive time span
    logic [TimeWidth-1:0] dticks;
    logic [TimeWidth-1:0] dns;
    logic [31:0]          nominal;   // never zero
    logic [1:0]           anchors;
  } job_t;

  // Queue write side, front end to queue.
  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  function automatic logic [TimeWidth-1:0] mag(input logic [TimeWidth-1:0] x);
    mag = x[TimeWidth-1] ? (TimeWidth'(0) - x) : x;
  endfunction

endpackage

// ----- sv/tti_front.sv -----
module tti_front import tti_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          nominal_rate_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [TimeWidth-1:0] ticks_i,
  input  logic [TimeWidth-1:0] gps_ns_i,
  input  logic                 q_full_i,
  output q_wr_t                q_wr_o,
  output logic [1:0]           count_o
);

  logic [TimeWidth-1:0] older_ticks_q, older_ns_q, newer_ticks_q, newer_ns_q;
  logic [TimeWidth-1:0] older_ticks_d, older_ns_d, newer_ticks_d, newer_ns_d;
  logic [1:0]           count_q, count_d;
  logic                 accept;
  logic [TimeWidth-1:0] dticks, dns;
  logic [31:0]          nominal;
  job_t                 job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign count_o    = count_q;

  always_comb begin
    older_ticks_d = older_ticks_q;
    older_ns_d    = older_ns_q;
    newer_ticks_d = newer_ticks_q;
    newer_ns_d    = newer_ns_q;
    count_d       = count_q;
    if (command_i == CMD_ANCHOR) begin
      older_ticks_d = newer_ticks_q;
      older_ns_d    = newer_ns_q;
      newer_ticks_d = ticks_i;
      newer_ns_d    = gps_ns_i;
      count_d       = (count_q == 2'd2) ? 2'd2 : count_q + 2'd1;
    end
  end

  assign dticks  = newer_ticks_d - older_ticks_d;
  assign dns     = newer_ns_d - older_ns_d;
  assign nominal = (nominal_rate_i == 32'd0) ? 32'd1 : nominal_rate_i;

  always_comb begin
    job          = '0;
    job.dticks   = dticks;
    job.dns      = dns;
    job.nominal  = nominal;
    job.anchors  = count_d;
    job.op_a     = ticks_i - newer_ticks_d;
    job.drift_en = (count_d == 2'd2) && (dns != '0) && !dns[TimeWidth-1];
    if (count_d == 2'd2) begin
      job.base_ns = newer_ns_d;
      job.mul_en  = (dticks != '0);
      job.op_b    = dns;
      job.op_d    = dticks;
    end else if (count_d == 2'd1) begin
      job.base_ns = newer_ns_d;
      job.mul_en  = 1'b1;
      job.op_b    = NsPerS;
      job.op_d    = TimeWidth'(nominal);
    end
  end

  assign q_wr_o.push = accept;
  assign q_wr_o.job  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_ticks_q <= '0;
      older_ns_q    <= '0;
      newer_ticks_q <= '0;
      newer_ns_q    <= '0;
      count_q       <= '0;
    end else if (accept) begin
      older_ticks_q <= older_ticks_d;
      older_ns_q    <= older_ns_d;
      newer_ticks_q <= newer_ticks_d;
      newer_ns_q    <= newer_ns_d;
      count_q       <= count_d;
    end
  end

endmodule

// ----- sv/tti_queue.sv -----
module tti_queue import tti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t q_wr_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output job_t  job_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (q_wr_i.push) begin
      mem_q[wr_ptr_q] <= q_wr_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (q_wr_i.push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (q_wr_i.push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !q_wr_i.push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ----- sv/tti_muldiv.sv -----
module tti_muldiv import tti_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TimeWidth-1:0] a_i,
  input  logic [TimeWidth-1:0] b_i,
  input  logic [TimeWidth-1:0] d_i,
  output logic                 done_o,
  output logic [TimeWidth-1:0] q_o
);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_DIV  = 4'b0100,
    MD_FIN  = 4'b1000
  } md_state_e;

  md_state_e            state_q, state_d;
  logic                 neg_q;
  logic [TimeWidth-1:0] ma_q, mb_q, md_q, rem_q, q_q;
  logic [ProdWidth-1:0] acc_q;
  logic [6:0]           cnt_q;
  logic                 done_q;

  logic [31:0]          a_part, b_part;
  logic [63:0]          pp;
  logic [ProdWidth-1:0] pp_sh;
  logic [TimeWidth:0]   rem_sh;
  logic                 ge;

  // Four 32x32 partial products, one per cycle.
  always_comb begin
    a_part = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    b_part = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    pp     = a_part * b_part;
    case ({cnt_q[1], cnt_q[0]})
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Restoring division, one quotient bit per cycle; the quotient shifts into acc.
  assign rem_sh = {rem_q, acc_q[ProdWidth-1]};
  assign ge     = (rem_sh >= {1'b0, md_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: if (start_i) state_d = MD_MUL;
      MD_MUL:  if (cnt_q[1:0] == 2'd3) state_d = MD_DIV;
      MD_DIV:  if (cnt_q == 7'd127) state_d = MD_FIN;
      MD_FIN:  state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        neg_q <= a_i[TimeWidth-1] ^ b_i[TimeWidth-1] ^ d_i[TimeWidth-1];
        ma_q  <= mag(a_i);
        mb_q  <= mag(b_i);
        md_q  <= mag(d_i);
        acc_q <= '0;
        rem_q <= '0;
      end
      MD_MUL: acc_q <= acc_q + pp_sh;
      MD_DIV: begin
        rem_q <= ge ? TimeWidth'(rem_sh - {1'b0, md_q}) : rem_sh[TimeWidth-1:0];
        acc_q <= {acc_q[ProdWidth-2:0], ge};
      end
      MD_FIN: q_q <= neg_q ? (TimeWidth'(0) - acc_q[TimeWidth-1:0])
                           : acc_q[TimeWidth-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MD_FIN);
      if (state_q != state_d) cnt_q <= '0;
      else if (state_q != MD_IDLE) cnt_q <= cnt_q + 7'd1;
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

// ----- sv/tti_back.sv -----
module tti_back import tti_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  job_t                 job_i,
  output logic                 job_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TimeWidth-1:0] time_ns_o,
  output logic [TimeWidth-1:0] drift_ppb_o,
  output logic [1:0]           anchors_held_o
);

  typedef enum logic [4:0] {
    BK_IDLE  = 5'b00001,
    BK_TIME  = 5'b00010,
    BK_MEAS  = 5'b00100,
    BK_DRIFT = 5'b01000,
    BK_DONE  = 5'b10000
  } bk_state_e;

  bk_state_e            state_q;
  job_t                 job_q;
  logic                 start_q;
  logic [TimeWidth-1:0] time_q, meas_q, drift_q;
  logic [TimeWidth-1:0] op_a, op_b, op_d, md_quot;
  logic                 md_done;
  logic                 out_valid_q, load;
  logic [TimeWidth-1:0] time_out_q, drift_out_q;
  logic [1:0]           anchors_out_q;

  always_comb begin
    op_a = job_q.op_a;
    op_b = job_q.op_b;
    op_d = job_q.op_d;
    case (state_q)
      BK_MEAS: begin
        op_a = job_q.dticks;
        op_b = NsPerS;
        op_d = job_q.dns;
      end
      BK_DRIFT: begin
        op_a = meas_q - TimeWidth'(job_q.nominal);
        op_b = NsPerS;
        op_d = TimeWidth'(job_q.nominal);
      end
      default: ;
    endcase
  end

  tti_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (op_a),
    .b_i     (op_b),
    .d_i     (op_d),
    .done_o  (md_done),
    .q_o     (md_quot)
  );

  assign job_pop_o = (state_q == BK_IDLE);
  assign load      = (state_q == BK_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && job_valid_i) job_q <= job_i;
    if (state_q == BK_TIME && !job_q.mul_en) time_q <= job_q.base_ns;
    if (state_q == BK_TIME && job_q.mul_en && md_done) time_q <= job_q.base_ns + md_quot;
    if (state_q == BK_TIME && !job_q.drift_en) drift_q <= '0;
    if (state_q == BK_MEAS && md_done) meas_q <= md_quot;
    if (state_q == BK_DRIFT && md_done) drift_q <= md_quot;
    if (load) begin
      time_out_q    <= time_q;
      drift_out_q   <= drift_q;
      anchors_out_q <= job_q.anchors;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        BK_IDLE: if (job_valid_i) begin
          state_q <= BK_TIME;
          start_q <= job_i.mul_en;
        end
        BK_TIME: if (!job_q.mul_en || md_done) begin
          state_q <= job_q.drift_en ? BK_MEAS : BK_DONE;
          start_q <= job_q.drift_en;
        end
        BK_MEAS: if (md_done) begin
          state_q <= BK_DRIFT;
          start_q <= 1'b1;
        end
        BK_DRIFT: if (md_done) state_q <= BK_DONE;
        BK_DONE:  if (load) state_q <= BK_IDLE;
        default:  state_q <= BK_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign time_ns_o      = time_out_q;
  assign drift_ppb_o    = drift_out_q;
  assign anchors_held_o = anchors_out_q;

endmodule

// ----- sv/tick_to_time_interpolator_core.sv -----
// Tick-to-time interpolator. Each request either records an anchor (command 0: a tick
// count paired with GPS nanoseconds) or resolves a tick count (command 1). Every
// request returns one result: the time for its tick count after the update, the drift
// against nominal_rate_hz in parts per billion, and the number of anchors held (0 to 2).
// With two anchors the time follows the measured slope from the newer anchor; with one
// the nominal rate is used; with none the time is 0. Products are exact and divisions
// truncate toward zero. The front end updates the anchors and snapshots the operands
// into a two-entry queue, so it keeps accepting requests while the back end computes,
// until the queue is full. All arithmetic runs on one shared multiply-divide unit that
// forms the exact 64x64 product and then runs a restoring division. A request takes
// at most one operation for the time and two more for the drift when the drift is
// determined.
module tick_to_time_interpolator_core import tti_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 nominal_rate_hz_we_i,
  input  logic [31:0]          nominal_rate_hz_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [TimeWidth-1:0] ticks_i,
  input  logic [TimeWidth-1:0] gps_ns_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TimeWidth-1:0] time_ns_o,
  output logic [TimeWidth-1:0] drift_ppb_o,
  output logic [1:0]           anchors_held_o
);

  // The nominal rate register resets to one hertz; zero is mapped to one downstream.
  logic [31:0] nominal_rate_q;
  q_wr_t       q_wr;
  logic        q_full, q_valid, q_pop;
  job_t        q_job;
  logic [1:0]  anchor_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_rate_q <= 32'd1;
    end else if (nominal_rate_hz_we_i) begin
      nominal_rate_q <= nominal_rate_hz_i;
    end
  end

  tti_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .nominal_rate_i (nominal_rate_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .ticks_i        (ticks_i),
    .gps_ns_i       (gps_ns_i),
    .q_full_i       (q_full),
    .q_wr_o         (q_wr),
    .count_o        (anchor_cnt)
  );

  tti_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_wr_i  (q_wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  tti_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_job),
    .job_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .time_ns_o      (time_ns_o),
    .drift_ppb_o    (drift_ppb_o),
    .anchors_held_o (anchors_held_o)
  );

  // The queue must never be written while it is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_wr.push |-> !q_full)
    else $error("request queue overflow");

  // An accepted anchor leaves at least one anchor held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_ANCHOR) |=> anchor_cnt != 2'd0)
    else $error("anchor count not updated");

  // The anchor count saturates at two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(anchor_cnt) == 2'd2 |-> anchor_cnt == 2'd2)
    else $error("anchor count left saturation");

endmodule

// ----- tb/sv/tb_tick_to_time_interpolator_core.sv -----
module tb_tick_to_time_interpolator_core;
  import tti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The slowest request runs one time operation and two drift operations on
  // the shared multiply-divide unit. The drain wait at the end and the idle gap
  // before a rate change both last DrainCycles.
  localparam int unsigned DrainCycles = 600;

  typedef struct packed {
    logic [63:0] time_ns;
    logic [63:0] drift_ppb;
    logic [1:0]  anchors_held;
  } result_t;

  // One row of the directed table. Rows with has_typed set carry an expected
  // result that is plain from the definition. All other rows use the predictor.
  typedef struct packed {
    cmd_e        command;
    logic [63:0] ticks;
    logic [63:0] gps_ns;
    logic        has_typed;
    result_t     typed;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        rate_we = 1'b0;
  logic [31:0] rate_wdata = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cmd_e        command = CMD_RESOLVE;
  logic [63:0] ticks = 64'd0;
  logic [63:0] gps_ns = 64'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] time_ns;
  logic [63:0] drift_ppb;
  logic [1:0]  anchors_held;

  // Predictor copy of the anchor state and of the rate register.
  logic [63:0] old_ticks_q, old_ns_q, new_ticks_q, new_ns_q;
  logic [1:0]  anchor_cnt_q;
  logic [31:0] rate_q;

  result_t pending_results[$];
  // Typed expectations queued by the driver for the rows that carry one.
  logic    typed_valid[$];
  result_t typed_results[$];

  int unsigned errors = 0;
  bit          idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_to_time_interpolator_core i_dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .nominal_rate_hz_we_i (rate_we),
    .nominal_rate_hz_i    (rate_wdata),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .command_i            (command),
    .ticks_i              (ticks),
    .gps_ns_i             (gps_ns),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .time_ns_o            (time_ns),
    .drift_ppb_o          (drift_ppb),
    .anchors_held_o       (anchors_held)
  );

  // Signed (a * b) / d with an exact 128-bit product and truncation toward
  // zero. The divisor is never zero here.
  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] d);
    logic         neg;
    logic [127:0] am, bm, dm, q;
    neg = a[63] ^ b[63] ^ d[63];
    am  = {64'd0, a[63] ? -a : a};
    bm  = {64'd0, b[63] ? -b : b};
    dm  = {64'd0, d[63] ? -d : d};
    q   = (am * bm) / dm;
    return neg ? -q[63:0] : q[63:0];
  endfunction

  // A rate of zero behaves as one hertz.
  function automatic logic [63:0] effective_rate();
    return (rate_q == 32'd0) ? 64'd1 : {32'd0, rate_q};
  endfunction

  // Applies one request to the anchor state and returns the time, drift and
  // anchor count that the block should report for it.
  function automatic result_t interpolate(cmd_e cmd, logic [63:0] t, logic [63:0] g);
    result_t     r;
    logic [63:0] span_ticks, span_ns, measured;
    if (cmd == CMD_ANCHOR) begin
      old_ticks_q = new_ticks_q;
      old_ns_q    = new_ns_q;
      new_ticks_q = t;
      new_ns_q    = g;
      if (anchor_cnt_q < 2'd2) anchor_cnt_q = anchor_cnt_q + 2'd1;
    end
    span_ticks = new_ticks_q - old_ticks_q;
    span_ns    = new_ns_q - old_ns_q;
    // Time: measured slope with two anchors, nominal rate with one, else 0.
    if (anchor_cnt_q == 2'd2) begin
      if (span_ticks == 64'd0) r.time_ns = new_ns_q;
      else r.time_ns = new_ns_q + scaled_quotient(t - new_ticks_q, span_ns, span_ticks);
    end else if (anchor_cnt_q == 2'd1) begin
      r.time_ns = new_ns_q + scaled_quotient(t - new_ticks_q, NsPerS, effective_rate());
    end else begin
      r.time_ns = 64'd0;
    end
    // Drift needs two anchors and a strictly positive time span.
    if (anchor_cnt_q == 2'd2 && span_ns != 64'd0 && !span_ns[63]) begin
      measured    = scaled_quotient(span_ticks, NsPerS, span_ns);
      r.drift_ppb = scaled_quotient(measured - effective_rate(), NsPerS, effective_rate());
    end else begin
      r.drift_ppb = 64'd0;
    end
    r.anchors_held = anchor_cnt_q;
    return r;
  endfunction

  // Input side: on each accepted request the prediction is made, and the
  // typed value replaces it where the directed row carries one.
  always @(posedge clk or negedge rst_n) begin
    result_t pred;
    if (!rst_n) begin
      old_ticks_q  <= 64'd0;
      old_ns_q     <= 64'd0;
      new_ticks_q  <= 64'd0;
      new_ns_q     <= 64'd0;
      anchor_cnt_q <= 2'd0;
      rate_q       <= 32'd1;
    end else begin
      if (rate_we) rate_q = rate_wdata;
      if (in_valid && in_ready) begin
        pred = interpolate(command, ticks, gps_ns);
        if (typed_valid.pop_front()) pending_results.push_back(typed_results.pop_front());
        else begin
          void'(typed_results.pop_front());
          pending_results.push_back(pred);
        end
      end
    end
  end

  // Output side: every accepted result is checked against the oldest one due.
  always @(posedge clk) begin
    result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: time %h drift %h anchors %0d",
                 $time, time_ns, drift_ppb, anchors_held);
        errors++;
      end else begin
        due = pending_results.pop_front();
        if (time_ns !== due.time_ns) begin
          $display("%0t: time_ns expected %h actual %h", $time, due.time_ns, time_ns);
          errors++;
        end
        if (drift_ppb !== due.drift_ppb) begin
          $display("%0t: drift_ppb expected %h actual %h", $time, due.drift_ppb, drift_ppb);
          errors++;
        end
        if (anchors_held !== due.anchors_held) begin
          $display("%0t: anchors_held expected %0d actual %0d", $time, due.anchors_held,
                   anchors_held);
          errors++;
        end
      end
    end
  end

  // The result side stalls at random, except during the quiet stretch.
  always @(negedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 19) : 1'b1;
  end

  // Presents one request and holds it until it is accepted. Idle cycles with
  // valid low are inserted before it at random while idling is on.
  task automatic send_request(cmd_e cmd, logic [63:0] t, logic [63:0] g, logic has_typed,
                              result_t typed);
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_valid.push_back(has_typed);
    typed_results.push_back(typed);
    in_valid <= 1'b1;
    command  <= cmd;
    ticks    <= t;
    gps_ns   <= g;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Waits until every result has come back and the block has settled, then
  // writes the rate register for one cycle.
  task automatic write_rate(logic [31:0] value);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(negedge clk);
    rate_we    <= 1'b1;
    rate_wdata <= value;
    @(negedge clk);
    rate_we <= 1'b0;
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
  localparam result_t NoResult = '0;

  vector_t directed[] = '{
    // No anchor yet: time and drift are both 0.
    '{CMD_RESOLVE, 64'd5, 64'd99, 1'b1, '{64'd0, 64'd0, 2'd0}},
    '{CMD_RESOLVE, MaxPos, MinNeg, 1'b1, '{64'd0, 64'd0, 2'd0}},
    // One anchor at the origin at one hertz: one tick is one second.
    '{CMD_ANCHOR, 64'd0, 64'd0, 1'b1, '{64'd0, 64'd0, 2'd1}},
    '{CMD_RESOLVE, 64'd3, 64'd0, 1'b1, '{64'd3_000_000_000, 64'd0, 2'd1}},
    '{CMD_RESOLVE, -64'd2, 64'd0, 1'b1, '{-64'd2_000_000_000, 64'd0, 2'd1}},
    '{CMD_RESOLVE, MaxPos, 64'd0, 1'b0, NoResult},
    '{CMD_RESOLVE, MinNeg, 64'd0, 1'b0, NoResult},
    // Second anchor at exactly one tick per second: no drift.
    '{CMD_ANCHOR, 64'd10, 64'd10_000_000_000, 1'b1,
      '{64'd10_000_000_000, 64'd0, 2'd2}},
    '{CMD_RESOLVE, 64'd12, 64'd0, 1'b1, '{64'd12_000_000_000, 64'd0, 2'd2}},
    // Same tick on both anchors: the newer time comes back. The measured rate
    // is zero, so at one hertz the drift is minus one billion ppb.
    '{CMD_ANCHOR, 64'd10, 64'd10_000_000_500, 1'b0, NoResult},
    '{CMD_RESOLVE, 64'd77, 64'd0, 1'b1,
      '{64'd10_000_000_500, -64'd1_000_000_000, 2'd2}},
    // Time going backward between anchors: drift stays 0.
    '{CMD_ANCHOR, 64'd20, 64'd5, 1'b0, NoResult},
    '{CMD_RESOLVE, 64'd30, 64'd0, 1'b0, NoResult},
    // Equal times on both anchors: zero span, drift 0.
    '{CMD_ANCHOR, 64'd40, 64'd5, 1'b0, NoResult},
    // A slope with real drift, then the extremes of every field.
    '{CMD_ANCHOR, 64'd50, 64'd7, 1'b0, NoResult},
    '{CMD_RESOLVE, 64'd1000, 64'd0, 1'b0, NoResult},
    '{CMD_ANCHOR, MaxPos, MaxPos, 1'b0, NoResult},
    '{CMD_ANCHOR, MinNeg, MinNeg, 1'b0, NoResult},
    '{CMD_RESOLVE, MaxPos, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NoResult},
    '{CMD_ANCHOR, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1'b0, NoResult},
    '{CMD_RESOLVE, MinNeg, 64'd0, 1'b0, NoResult},
    '{CMD_ANCHOR, 64'd0, MaxPos, 1'b0, NoResult},
    '{CMD_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFF, MaxPos, 1'b0, NoResult}
  };

  // Rates for the random phases: the zero value, both extremes and typical
  // oscillator frequencies. The last phase draws a random rate.
  logic [31:0] phase_rates[] = '{32'd0, 32'hFFFF_FFFF, 32'd10_000_000, 32'd1,
                                 32'd125_000_000, 32'd0};

  initial begin
    logic [63:0] t_base, ns_base, t_step, ns_step;
    int unsigned kind;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_request(directed[i].command, directed[i].ticks, directed[i].gps_ns,
                   directed[i].has_typed, directed[i].typed);
    end

    foreach (phase_rates[p]) begin
      write_rate((p == phase_rates.size() - 1) ? $urandom : phase_rates[p]);
      t_base  = random_word() >> $urandom_range(63);
      ns_base = random_word() >> $urandom_range(63);
      // The middle phases run without any idling on either side.
      idle_on = (p != 2 && p != 3);
      repeat (100) begin
        kind = $urandom_range(99);
        if (kind < 55) begin
          // A well-formed anchor: ticks and time both move forward by a
          // plausible amount, so the slope and the drift stay meaningful.
          t_step  = 64'($urandom_range(1, 1 << 24)) << $urandom_range(8);
          ns_step = 64'($urandom_range(1, 1 << 30)) << $urandom_range(12);
          t_base  = t_base + t_step;
          ns_base = ns_base + ns_step;
          send_request(CMD_ANCHOR, t_base, ns_base, 1'b0, NoResult);
        end else if (kind < 85) begin
          // A resolve near the newer anchor, before or after it.
          send_request(CMD_RESOLVE, t_base + 64'($signed($urandom_range(0, 1 << 26)) -
                       (1 << 25)), random_word(), 1'b0, NoResult);
        end else if (kind < 93) begin
          // Noise: any value in every field.
          send_request(cmd_e'($urandom_range(1)), random_word(), random_word(), 1'b0,
                       NoResult);
        end else begin
          // A broken sequence: repeated tick, or time standing still or
          // running backward.
          ns_base = ns_base - 64'($urandom_range(0, 1000));
          send_request(CMD_ANCHOR, t_base + 64'($urandom_range(1)), ns_base, 1'b0,
                       NoResult);
        end
      end
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
